/* design/pairwise_l1_distance_matrix_top_macros.svh */
// assertion macros for the pairwise l1 distance matrix block
// used by pairwise_l1_distance_matrix_top; expects clk and arst_n in scope
`ifndef PAIRWISE_L1_DISTANCE_MATRIX_TOP_MACROS_SVH
`define PAIRWISE_L1_DISTANCE_MATRIX_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PL1DM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pl1dm assertion failed");

// antecedent implies consequent in the next cycle
`define PL1DM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pl1dm assertion failed");

`else

`define PL1DM_ASSERT_IMP(lbl, ante, cons)
`define PL1DM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/pl1dm_pkg.sv */
// shared types and constants for the pairwise l1 distance matrix block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pl1dm_pkg;

	localparam int ELEM_W = 8;
	localparam int REG_W  = 7;
	localparam int IDX_W  = 6;
	localparam int DIST_W = 14;
	localparam int CFG_W  = 2;

	localparam logic [DIST_W-1:0] SUM_LIMIT = '1;

	typedef enum logic [CFG_W-1:0] {
		REG_VECTOR_LENGTH = 2'd0,
		REG_CENTER_COUNT  = 2'd1
	} cfg_reg_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic acc;    // input transfer this cycle
		logic upd;    // stage 1 holds an element to accumulate
		logic first;  // stage 1 element is the first of its vector
		logic shift;  // move sums one cell toward the head
	} cell_ctl_t;

endpackage

`default_nettype wire

/* design/pairwise_l1_distance_matrix_top.sv */
// Pairwise L1 distance matrix. Center vectors stream in one byte element per
// transfer. A row of cells, one per stored center, each keeps that center's
// bytes in a small local memory; each cell below the current center updates
// its own running sum of absolute differences from the stage 1 element, all
// in parallel. After the last element of center i the input stalls while it
// is in stage 1 and while the row drains: results (i,0)..(i,i-1) shift out
// of the cell chain, then the zero diagonal (i,i), one per cycle while
// out_ready is high. No clearing pass after reset; stored centers are kept
// across writes to the decoded registers, which restart framing.
`timescale 1ns / 1ps
`default_nettype none

`include "pairwise_l1_distance_matrix_top_macros.svh"

module pairwise_l1_distance_matrix_top #(
	parameter int MAX_CENTERS = 64,
	parameter int MAX_DIM     = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [pl1dm_pkg::ELEM_W-1:0]   element_value,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [pl1dm_pkg::IDX_W-1:0]    row_index,
	output logic [pl1dm_pkg::IDX_W-1:0]    col_index,
	output logic [pl1dm_pkg::DIST_W-1:0]   distance,
	output logic                           last_of_run,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [pl1dm_pkg::CFG_W-1:0]    cfg_index,
	input  wire  [pl1dm_pkg::REG_W-1:0]    cfg_data
);
	import pl1dm_pkg::*;

	localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW = $clog2(MAX_CENTERS);
	localparam int LW = $clog2(MAX_DIM + 1);
	localparam int NW = $clog2(MAX_CENTERS + 1);

	logic [REG_W-1:0]  vec_len_q;
	logic [REG_W-1:0]  ctr_cnt_q;
	logic [EW-1:0]     elem_q;
	logic [CW-1:0]     center_q;

	logic [LW-1:0]     len;
	logic [NW-1:0]     cnt;
	logic              restart;
	logic [EW-1:0]     elem_eff;
	logic [CW-1:0]     center_eff;
	logic              is_last;
	logic              in_fire;
	logic              out_fire;
	logic              cfg_fire;
	logic              cfg_known;

	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic [CW-1:0]     center_s1;
	logic [ELEM_W-1:0] value_s1;

	logic              drain_q;
	logic [CW-1:0]     col_q;
	logic [CW-1:0]     row_q;
	logic              diag;

	cell_ctl_t         ctl;
	logic [DIST_W-1:0] chain [MAX_CENTERS+1];

	// clamp registers to their legal ranges
	always_comb begin
		if (vec_len_q == '0) begin
			len = LW'(1);
		end else if (int'(vec_len_q) > MAX_DIM) begin
			len = LW'(MAX_DIM);
		end else begin
			len = LW'(vec_len_q);
		end
		if (ctr_cnt_q == '0) begin
			cnt = NW'(1);
		end else if (int'(ctr_cnt_q) > MAX_CENTERS) begin
			cnt = NW'(MAX_CENTERS);
		end else begin
			cnt = NW'(ctr_cnt_q);
		end
		restart    = (int'(elem_q) >= int'(len)) || (int'(center_q) >= int'(cnt));
		elem_eff   = restart ? '0 : elem_q;
		center_eff = restart ? '0 : center_q;
		is_last    = (int'(elem_eff) + 1) >= int'(len);
	end

	always_comb begin
		cfg_known = (cfg_index == REG_VECTOR_LENGTH) || (cfg_index == REG_CENTER_COUNT);
		in_ready  = !drain_q && !(valid_s1 && last_s1);
		cfg_ready = 1'b1;
		in_fire   = in_valid && in_ready;
		out_fire  = out_valid && out_ready;
		cfg_fire  = cfg_valid && cfg_ready;
		diag      = (col_q == row_q);
	end

	// configuration registers and framing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q <= REG_W'(64);
			ctr_cnt_q <= REG_W'(64);
			elem_q    <= '0;
			center_q  <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_VECTOR_LENGTH: vec_len_q <= cfg_data;
				REG_CENTER_COUNT:  ctr_cnt_q <= cfg_data;
				default: ;
			endcase
			if (cfg_known) begin
				elem_q   <= '0;
				center_q <= '0;
			end
		end else if (in_fire) begin
			if (is_last) begin
				elem_q   <= '0;
				center_q <= ((int'(center_eff) + 1) >= int'(cnt)) ? '0 : center_eff + 1'b1;
			end else begin
				elem_q   <= elem_eff + 1'b1;
				center_q <= center_eff;
			end
		end
	end

	// stage 1: element waits for the cell memory reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1  <= (elem_eff == '0);
			last_s1   <= is_last;
			center_s1 <= center_eff;
			value_s1  <= element_value;
		end
	end

	// result drain: sums walk toward cell 0, one transfer per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (valid_s1 && last_s1) begin
			drain_q <= 1'b1;
			col_q   <= '0;
			row_q   <= center_s1;
		end else if (out_fire) begin
			if (diag) begin
				drain_q <= 1'b0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		ctl.acc   = in_fire;
		ctl.upd   = valid_s1;
		ctl.first = first_s1;
		ctl.shift = out_fire && !diag;
	end

	assign chain[MAX_CENTERS] = '0;

	for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_cell
		pl1dm_cell #(
			.MAX_CENTERS (MAX_CENTERS),
			.MAX_DIM     (MAX_DIM),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.center    (center_eff),
			.elem      (elem_eff),
			.wdata     (element_value),
			.center_s1 (center_s1),
			.value_s1  (value_s1),
			.sum_in    (chain[i+1]),
			.sum_out   (chain[i])
		);
	end

	always_comb begin
		out_valid   = drain_q;
		row_index   = IDX_W'(row_q);
		col_index   = IDX_W'(col_q);
		distance    = diag ? '0 : chain[0];
		last_of_run = diag;
	end

	`PL1DM_ASSERT_NEXT(a_last_starts_drain, valid_s1 && last_s1, drain_q && col_q == '0)
	`PL1DM_ASSERT_NEXT(a_diag_ends_drain, out_fire && diag, !drain_q)
	`PL1DM_ASSERT_IMP(a_col_not_past_row, drain_q, col_q <= row_q)
	`PL1DM_ASSERT_NEXT(a_last_elem_to_s1, in_fire && is_last, valid_s1 && last_s1)

endmodule

`default_nettype wire

/* design/pl1dm_cell.sv */
// one cell of the distance chain: stores one center and its running l1 sum
// depends on pl1dm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pl1dm_cell #(
	parameter int MAX_CENTERS = 64,
	parameter int MAX_DIM     = 64,
	parameter int IDX         = 0,
	localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int CW = $clog2(MAX_CENTERS)
) (
	input  wire                           clk,
	input  wire  pl1dm_pkg::cell_ctl_t    ctl,
	input  wire  [CW-1:0]                 center,
	input  wire  [EW-1:0]                 elem,
	input  wire  [pl1dm_pkg::ELEM_W-1:0]  wdata,
	input  wire  [CW-1:0]                 center_s1,
	input  wire  [pl1dm_pkg::ELEM_W-1:0]  value_s1,
	input  wire  [pl1dm_pkg::DIST_W-1:0]  sum_in,
	output logic [pl1dm_pkg::DIST_W-1:0]  sum_out
);
	import pl1dm_pkg::*;

	logic [ELEM_W-1:0] mem [MAX_DIM];
	logic [ELEM_W-1:0] rd_s1;
	logic [DIST_W-1:0] sum_q;
	logic [ELEM_W-1:0] diff;
	logic [DIST_W-1:0] base;
	logic [DIST_W:0]   total;
	logic              active;

	always_ff @(posedge clk) begin
		if (ctl.acc && center == CW'(IDX)) begin
			mem[elem] <= wdata;
		end
		if (ctl.acc) begin
			rd_s1 <= mem[elem];
		end
	end

	always_comb begin
		active = center_s1 > CW'(IDX);
		diff   = (value_s1 > rd_s1) ? (value_s1 - rd_s1) : (rd_s1 - value_s1);
		base   = ctl.first ? '0 : sum_q;
		total  = {1'b0, base} + (DIST_W+1)'(diff);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sum_q <= sum_in;
		end else if (ctl.upd && active) begin
			// saturate at the top of the sum range
			sum_q <= total[DIST_W] ? SUM_LIMIT : total[DIST_W-1:0];
		end
	end

	assign sum_out = sum_q;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for pairwise_l1_distance_matrix_top: streams center vectors
// under random stalls, predicts every matrix entry and compares it field by field
// depends on pl1dm_pkg and the block's rtl

module tb_top;
	import pl1dm_pkg::*;

	localparam int SLOT_COUNT     = 64;
	localparam int NUM_DIM        = 64;
	localparam int MAX_GAP        = 19;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTS     = 100;
	localparam int RANDOM_ITEMS   = 16;
	localparam int FRAME_ITEMS    = 16;

	// register indexes the block does not decode
	localparam logic [CFG_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DIST_W-1:0] l1_dist;
		logic              last;
	} matrix_entry_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ELEM_W-1:0] element_value;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic [DIST_W-1:0] distance;
	logic              last_of_run;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_index;
	logic [REG_W-1:0]  cfg_data;

	pairwise_l1_distance_matrix_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_index     (row_index),
		.col_index     (col_index),
		.distance      (distance),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor state
	logic [ELEM_W-1:0] center_bytes [SLOT_COUNT][NUM_DIM];
	logic [DIST_W-1:0] l1_sums [SLOT_COUNT];
	int unsigned       elem_pos;
	int unsigned       center_pos;
	logic [REG_W-1:0]  len_reg;
	logic [REG_W-1:0]  count_reg;
	matrix_entry_t     expected_entries [$];

	int error_count  = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;
	bit hold_req     = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned clamp_reg(input logic [REG_W-1:0] v, input int unsigned hi);
		if (v == '0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		for (int j = 0; j < SLOT_COUNT; j++)
			l1_sums[j] = '0;
		elem_pos = 0;
		center_pos = 0;
	endfunction

	function automatic void apply_register(input logic [CFG_W-1:0] idx,
			input logic [REG_W-1:0] data);
		case (idx)
			REG_VECTOR_LENGTH: begin
				len_reg = data;
				restart_frame();
			end
			REG_CENTER_COUNT: begin
				count_reg = data;
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// accumulate one element and queue the row of entries when a center completes
	function automatic void predict_element(input logic [ELEM_W-1:0] v);
		int unsigned   len;
		int unsigned   cnt;
		logic [ELEM_W-1:0] w;
		logic [DIST_W:0]   s;
		matrix_entry_t ent;
		len = clamp_reg(len_reg, NUM_DIM);
		cnt = clamp_reg(count_reg, SLOT_COUNT);
		if (elem_pos >= len || center_pos >= cnt)
			restart_frame();
		center_bytes[center_pos][elem_pos] = v;
		for (int j = 0; j < center_pos; j++) begin
			w = center_bytes[j][elem_pos];
			s = {1'b0, l1_sums[j]} + ((v > w) ? v - w : w - v);
			l1_sums[j] = (s > SUM_LIMIT) ? SUM_LIMIT : s[DIST_W-1:0];
		end
		if (elem_pos + 1 < len) begin
			elem_pos++;
			return;
		end
		for (int j = 0; j < center_pos; j++) begin
			ent.row     = IDX_W'(center_pos);
			ent.col     = IDX_W'(j);
			ent.l1_dist = l1_sums[j];
			ent.last    = 1'b0;
			expected_entries.push_back(ent);
		end
		ent.row     = IDX_W'(center_pos);
		ent.col     = IDX_W'(center_pos);
		ent.l1_dist = '0;
		ent.last    = 1'b1;
		expected_entries.push_back(ent);
		for (int j = 0; j < SLOT_COUNT; j++)
			l1_sums[j] = '0;
		elem_pos = 0;
		center_pos = (center_pos + 1 >= cnt) ? 0 : center_pos + 1;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("tb_top: mismatch: %s", msg);
	endtask

	function automatic logic [ELEM_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	// result check on every output transfer
	always @(posedge clk) begin : check_entry
		matrix_entry_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_entries.size() == 0) begin
				report_mismatch($sformatf("unexpected entry (%0d,%0d) distance %0d",
					row_index, col_index, distance));
			end else begin
				want = expected_entries.pop_front();
				if (row_index !== want.row)
					report_mismatch($sformatf("row_index %0d, want %0d", row_index, want.row));
				if (col_index !== want.col)
					report_mismatch($sformatf("col_index %0d, want %0d (row %0d)",
						col_index, want.col, want.row));
				if (distance !== want.l1_dist)
					report_mismatch($sformatf("distance %0d, want %0d at (%0d,%0d)",
						distance, want.l1_dist, want.row, want.col));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b at (%0d,%0d)",
						last_of_run, want.last, want.row, want.col));
			end
		end
	end

	// no transfer on any channel for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// result receiver with random stalls and one long hold-off on request
	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_element(input logic [ELEM_W-1:0] v);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (!in_ready);
		predict_element(v);
		items_sent++;
	endtask

	task automatic send_center(input int unsigned n);
		repeat (n) send_element(pick_byte());
	endtask

	// drop valid, let all queued entries drain, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_W-1:0] idx, input logic [REG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [REG_W-1:0] len_val, input logic [REG_W-1:0] cnt_val);
		wait_quiet();
		write_register(REG_VECTOR_LENGTH, len_val);
		write_register(REG_CENTER_COUNT, cnt_val);
	endtask

	// reset values: 64 elements, all zeros against all ones gives the largest distance
	task automatic test_reset_defaults();
		repeat (64) send_element('0);
		repeat (64) send_element('1);
	endtask

	task automatic test_single_element();
		configure(7'd1, 7'd4);
		send_element(8'd0);
		send_element(8'd255);
		send_element(8'd255);
		send_element(8'd0);
		// zero length acts as one
		configure(7'd0, 7'd3);
		send_element(8'd128);
		send_element(8'd1);
		send_element(8'd254);
	endtask

	task automatic test_single_center();
		configure(7'd2, 7'd1);
		send_element(8'd10);
		send_element(8'd200);
		send_element(8'd7);
		send_element(8'd3);
	endtask

	// writes to undecoded indexes must leave the half-done center alone
	task automatic test_spare_index();
		configure(7'd3, 7'd2);
		send_element(8'd0);
		send_element(8'd255);
		send_element(8'd100);
		send_element(8'd255);
		send_element(8'd0);
		wait_quiet();
		write_register(REG_SPARE_2, 7'd5);
		write_register(REG_SPARE_3, 7'd127);
		send_element(8'd30);
	endtask

	// a register write in the middle of a center restarts framing
	task automatic test_restart_midframe();
		configure(7'd2, 7'd3);
		send_element(8'd50);
		send_element(8'd60);
		send_element(8'd70);
		wait_quiet();
		write_register(REG_VECTOR_LENGTH, 7'd2);
		send_element(8'd1);
		send_element(8'd2);
		send_element(8'd3);
		send_element(8'd4);
	endtask

	task automatic test_length_clamp();
		configure(7'd127, 7'd1);
		send_center(NUM_DIM);
	endtask

	// count clamps to 64, the last center emits the longest row, then it wraps
	task automatic test_count_clamp();
		idle_on = 1'b0;
		configure(7'd0, 7'd127);
		send_center(SLOT_COUNT + 1);
		wait_quiet();
		idle_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		configure(7'd1, 7'd6);
		idle_on = 1'b0;
		hold_req = 1'b1;
		send_center(6);
		wait_quiet();
		idle_on = 1'b1;
	endtask

	task automatic test_random_frames();
		logic [REG_W-1:0] len_val;
		logic [REG_W-1:0] cnt_val;
		int unsigned eff_len;
		int unsigned eff_cnt;
		int unsigned centers;
		int unsigned cut;
		int first_item;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: len_val = '0;
				1: len_val = REG_W'($urandom_range(7, 16));
				default: len_val = REG_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 9))
				0: cnt_val = '0;
				1: cnt_val = REG_W'($urandom_range(13, 127));
				default: cnt_val = REG_W'($urandom_range(1, 12));
			endcase
			wait_quiet();
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					REG_W'($urandom_range(0, 127)));
			case ($urandom_range(0, 3))
				0: write_register(REG_VECTOR_LENGTH, len_val);
				1: write_register(REG_CENTER_COUNT, cnt_val);
				2: begin
					write_register(REG_CENTER_COUNT, cnt_val);
					write_register(REG_VECTOR_LENGTH, len_val);
				end
				default: begin
					write_register(REG_VECTOR_LENGTH, len_val);
					write_register(REG_CENTER_COUNT, cnt_val);
				end
			endcase
			eff_len = clamp_reg(len_reg, NUM_DIM);
			eff_cnt = clamp_reg(count_reg, SLOT_COUNT);
			// keep each frame short
			centers = FRAME_ITEMS / eff_len;
			if (centers < 1)
				centers = 1;
			if (centers > eff_cnt + 1)
				centers = eff_cnt + 1;
			centers = $urandom_range(1, centers);
			repeat (centers) send_center(eff_len);
			// sometimes leave a center unfinished for the next write to cut off
			if (eff_len > 1 && $urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, eff_len - 1);
				send_center(cut);
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element_value = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_VECTOR_LENGTH;
		cfg_data      = '0;
		len_reg       = 7'd64;
		count_reg     = 7'd64;
		restart_frame();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_single_element();
		test_single_center();
		test_spare_index();
		test_restart_midframe();
		test_length_clamp();
		test_count_clamp();
		test_backpressure();
		test_random_frames();

		wait_quiet();
		if (expected_entries.size() != 0)
			report_mismatch($sformatf("%0d entries never arrived", expected_entries.size()));
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/pl1dm_pkg.sv
design/pl1dm_cell.sv
design/pairwise_l1_distance_matrix_top.sv
bench/tb_top.sv
